// ===== hdl/turbine_speed_tracking_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Turbine speed tracking controller assertion macros
// Shorthand for the concurrent checks used in the controller RTL. Each macro
// samples on the rising edge of clock and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef TURBINE_SPEED_TRACKING_CONTROLLER_TOP_ASSERT_SVH
`define TURBINE_SPEED_TRACKING_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSTC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tstc_pkg.sv =====
// ----------------------------------------------------------------------------
// tstc_pkg
// Widths, register indexes and reset values of the turbine speed tracking
// controller.
// ----------------------------------------------------------------------------
package tstc_pkg;

   // Field widths.
   localparam int unsigned TorqueWidth    = 32;
   localparam int unsigned SpeedCmdWidth  = 16;
   localparam int unsigned SumWidth       = 48;
   localparam int unsigned TickWidth      = 20;
   localparam int unsigned HalfWinWidth   = 16;
   localparam int unsigned SpeedMagWidth  = 15;
   localparam int unsigned CoefWidth      = 16;

   // Configuration port.
   localparam int unsigned CsrIndexWidth  = 3;
   localparam int unsigned CsrDataWidth   = 20;

   localparam logic [CsrIndexWidth-1:0] CSR_HALF_WINDOW   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STARTUP_TICKS = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_STARTUP_SPEED = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REVERSAL      = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SPEED_RATIO   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_STEP_GAIN     = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD     = 3'd6;

   // Register reset values.
   localparam logic [HalfWinWidth-1:0]  HALF_WINDOW_RESET   = 16'd500;
   localparam logic [TickWidth-1:0]     STARTUP_TICKS_RESET = 20'd2000;
   localparam logic [SpeedMagWidth-1:0] STARTUP_SPEED_RESET = 15'd1280;
   localparam logic [SpeedMagWidth-1:0] REVERSAL_RESET      = 15'd3328;
   localparam logic [CoefWidth-1:0]     SPEED_RATIO_RESET   = 16'd34406;
   localparam logic [CoefWidth-1:0]     STEP_GAIN_RESET     = 16'd6554;
   localparam logic [CoefWidth-1:0]     THRESHOLD_RESET     = 16'd3277;

   // Iteration counts of the shared compare-subtract unit.
   localparam int unsigned DivSteps  = 48;
   localparam int unsigned SqrtSteps = 16;
   localparam int unsigned StepWidth = 6;

endpackage

// ===== hdl/turbine_speed_tracking_controller_top.sv =====
// ----------------------------------------------------------------------------
// turbine_speed_tracking_controller_top
// Optimal-torque speed tracking for a wind rotor: one torque item in, one
// speed command item out, with windowed averaging and a square-root target.
// ----------------------------------------------------------------------------
// Every torque item gives exactly one result item. An item that does not close
// a window is answered in the next cycle, so such items can follow one per
// cycle while the output is not stalled. An item that closes a window starts
// an evaluation: the magnitude of the sum, bit-serial division of the torque
// sum by the half-window length, the clamp to 32 bits and the square root,
// the division and the root on one shared compare-subtract unit, then three
// multiplies on one shared 20x16 multiplier with a difference step between
// them and a final decision step. The input is stalled during an evaluation
// and while a finished result waits at the output, so the item after a
// window-closing item is taken only once the evaluation has finished.
// Configuration writes are taken only while no evaluation runs.
`include "turbine_speed_tracking_controller_top_assert.svh"

module turbine_speed_tracking_controller_top (
   input  logic                                      clock,
   input  logic                                      reset,
   // Torque items.
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [tstc_pkg::TorqueWidth-1:0]   req_torque_sample,
   // Speed command items.
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [tstc_pkg::SpeedCmdWidth-1:0] rsp_speed_command,
   output logic                                      rsp_window_done,
   output logic signed [tstc_pkg::TorqueWidth-1:0]   rsp_average_torque,
   output logic                                      rsp_speed_changed,
   // Register writes.
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tstc_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [tstc_pkg::CsrDataWidth-1:0]         csr_wdata
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ABS      = 4'd1;
   localparam logic [3:0] ST_DIV      = 4'd2;
   localparam logic [3:0] ST_CLAMP    = 4'd3;
   localparam logic [3:0] ST_SQRT     = 4'd4;
   localparam logic [3:0] ST_MUL_TGT  = 4'd5;
   localparam logic [3:0] ST_DIFF     = 4'd6;
   localparam logic [3:0] ST_MUL_STEP = 4'd7;
   localparam logic [3:0] ST_MUL_THR  = 4'd8;
   localparam logic [3:0] ST_DECIDE   = 4'd9;

   localparam logic [tstc_pkg::StepWidth-1:0] DIV_LAST  =
      tstc_pkg::StepWidth'(tstc_pkg::DivSteps - 1);
   localparam logic [tstc_pkg::StepWidth-1:0] SQRT_LAST =
      tstc_pkg::StepWidth'(tstc_pkg::SqrtSteps - 1);

   // Configuration registers.
   logic [tstc_pkg::HalfWinWidth-1:0]  half_win_ff,  half_win_in;
   logic [tstc_pkg::TickWidth-1:0]     startup_ff,   startup_in;
   logic [tstc_pkg::SpeedMagWidth-1:0] st_speed_ff,  st_speed_in;
   logic [tstc_pkg::SpeedMagWidth-1:0] rev_speed_ff, rev_speed_in;
   logic [tstc_pkg::CoefWidth-1:0]     ratio_ff,     ratio_in;
   logic [tstc_pkg::CoefWidth-1:0]     gain_ff,      gain_in;
   logic [tstc_pkg::CoefWidth-1:0]     thresh_ff,    thresh_in;

   // Controller state.
   logic [3:0]                          state_ff,     state_in;
   logic [tstc_pkg::StepWidth-1:0]      step_ff,      step_in;
   logic [tstc_pkg::TickWidth-1:0]      tick_ff,      tick_in;
   logic                                in_startup_ff, in_startup_in;
   logic [tstc_pkg::SumWidth-1:0]       sum_ff,       sum_in;
   logic [tstc_pkg::SpeedCmdWidth-1:0]  cur_speed_ff, cur_speed_in;
   logic [tstc_pkg::TorqueWidth-1:0]    last_avg_ff,  last_avg_in;

   // Evaluation datapath.
   logic [tstc_pkg::SumWidth-1:0]       q_ff,         q_in;
   logic [15:0]                         rem_ff,       rem_in;
   logic [15:0]                         root_ff,      root_in;
   logic                                sum_neg_ff,   sum_neg_in;
   logic [tstc_pkg::TorqueWidth-1:0]    avg_ff,       avg_in;
   logic [35:0]                         prod_ff,      prod_in;
   logic [19:0]                         dmag_ff,      dmag_in;
   logic                                diff_neg_ff,  diff_neg_in;
   logic [19:0]                         smag_ff,      smag_in;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tstc_pkg::SpeedCmdWidth-1:0]  rsp_speed_ff, rsp_speed_in;
   logic                                rsp_done_ff,  rsp_done_in;
   logic [tstc_pkg::TorqueWidth-1:0]    rsp_avg_ff,   rsp_avg_in;
   logic                                rsp_chg_ff,   rsp_chg_in;

   logic        out_free;
   logic        req_accept;
   logic        csr_write;

   // Shared units.
   logic [31:0] sub_a, sub_b;
   logic [32:0] sub_diff;
   logic        sub_ge;
   logic [19:0] mul_a;
   logic [15:0] mul_b;
   logic [35:0] mul_res;

   // Window bookkeeping.
   logic [15:0] n_eff;
   logic [16:0] win_last;
   logic        start_over;
   logic [tstc_pkg::TickWidth-1:0] tick_eff;
   logic [tstc_pkg::TickWidth-1:0] tick_inc;
   logic        settle_done;
   logic        eval_now;
   logic [48:0] sum_add;
   logic [tstc_pkg::SumWidth-1:0] sum_sat;
   logic [tstc_pkg::SumWidth-1:0] sum_next;
   logic [tstc_pkg::SpeedCmdWidth-1:0] neg_startup;

   // Evaluation helpers.
   logic [16:0] div_rem_t;
   logic [17:0] sqrt_rem_t;
   logic [17:0] sqrt_trial;
   logic        q_over_neg;
   logic        q_over_pos;
   logic [15:0] cal_w;
   logic [19:0] target;
   logic [20:0] diff_up;
   logic [20:0] diff_dn;
   logic signed [22:0] cand;
   logic signed [22:0] neg_cand;
   logic [tstc_pkg::SpeedCmdWidth-1:0] cand_sat;
   logic        over_thresh;
   logic [tstc_pkg::SpeedCmdWidth-1:0] next_speed;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_speed_command  = rsp_speed_ff;
   assign rsp_window_done    = rsp_done_ff;
   assign rsp_average_torque = rsp_avg_ff;
   assign rsp_speed_changed  = rsp_chg_ff;

   // A half window of zero behaves as one tick.
   assign n_eff       = (half_win_ff == '0) ? 16'd1 : half_win_ff;
   assign win_last    = {n_eff, 1'b0} - 17'd1;
   assign start_over  = in_startup_ff && (tick_ff >= startup_ff);
   assign tick_eff    = start_over ? '0 : tick_ff;
   assign tick_inc    = tick_eff + 20'd1;
   assign settle_done = tick_eff >= {4'b0, n_eff};
   assign eval_now    = tick_eff >= {3'b0, win_last};

   // Saturating accumulation of the averaging half of the window.
   assign sum_add  = {sum_ff[47], sum_ff} + {{17{req_torque_sample[31]}}, req_torque_sample};
   assign sum_sat  = (sum_add[48] != sum_add[47]) ?
                     (sum_add[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : sum_add[47:0];
   assign sum_next = settle_done ? sum_sat : sum_ff;

   assign neg_startup = 16'd0 - {1'b0, st_speed_ff};

   assign cal_w = cur_speed_ff[15] ? (16'd0 - cur_speed_ff) : cur_speed_ff;

   // Compare-subtract operands for the divider and the square root.
   assign div_rem_t  = {rem_ff, q_ff[47]};
   assign sqrt_rem_t = {rem_ff, q_ff[31:30]};
   assign sqrt_trial = {root_ff, 2'b01};

   always_comb begin
      sub_a = '0;
      sub_b = '0;
      case (state_ff)
         ST_DIV: begin
            sub_a = {15'b0, div_rem_t};
            sub_b = {16'b0, n_eff};
         end
         ST_SQRT: begin
            sub_a = {14'b0, sqrt_rem_t};
            sub_b = {14'b0, sqrt_trial};
         end
         default: ;
      endcase
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[32];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_TGT: begin
            mul_a = {4'b0, root_ff};
            mul_b = ratio_ff;
         end
         ST_MUL_STEP: begin
            mul_a = dmag_ff;
            mul_b = gain_ff;
         end
         ST_MUL_THR: begin
            mul_a = {4'b0, cal_w};
            mul_b = thresh_ff;
         end
         default: ;
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // Average clamp limits: the negative side reaches one further.
   assign q_over_pos = (q_ff[47:31] != '0);
   assign q_over_neg = (q_ff[47:32] != '0) || (q_ff[31] && (q_ff[30:0] != '0));

   assign target  = prod_ff[31:12];
   assign diff_up = {1'b0, target} - {5'b0, cal_w};
   assign diff_dn = {5'b0, cal_w} - {1'b0, target};

   // Candidate magnitude is |speed| plus the signed step, commanded negative.
   assign cand     = diff_neg_ff ? ($signed({7'b0, cal_w}) - $signed({3'b0, smag_ff}))
                                 : ($signed({7'b0, cal_w}) + $signed({3'b0, smag_ff}));
   assign neg_cand = -cand;
   assign cand_sat = (neg_cand > 23'sd32767)  ? 16'h7FFF :
                     (neg_cand < -23'sd32768) ? 16'h8000 : neg_cand[15:0];

   // A zero speed always counts as a change beyond the threshold.
   assign over_thresh = (cal_w == '0) || ({smag_ff, 16'b0} > prod_ff);
   assign next_speed  = !over_thresh ? cur_speed_ff :
                        avg_ff[31]   ? cand_sat : (16'd0 - {1'b0, rev_speed_ff});

   always_comb begin
      half_win_in   = half_win_ff;
      startup_in    = startup_ff;
      st_speed_in   = st_speed_ff;
      rev_speed_in  = rev_speed_ff;
      ratio_in      = ratio_ff;
      gain_in       = gain_ff;
      thresh_in     = thresh_ff;
      state_in      = state_ff;
      step_in       = step_ff;
      tick_in       = tick_ff;
      in_startup_in = in_startup_ff;
      sum_in        = sum_ff;
      cur_speed_in  = cur_speed_ff;
      last_avg_in   = last_avg_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      sum_neg_in    = sum_neg_ff;
      avg_in        = avg_ff;
      prod_in       = prod_ff;
      dmag_in       = dmag_ff;
      diff_neg_in   = diff_neg_ff;
      smag_in       = smag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_speed_in  = rsp_speed_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_chg_in    = rsp_chg_ff;

      if (csr_write) begin
         case (csr_index)
            tstc_pkg::CSR_HALF_WINDOW:   half_win_in  = csr_wdata[15:0];
            tstc_pkg::CSR_STARTUP_TICKS: startup_in   = csr_wdata;
            tstc_pkg::CSR_STARTUP_SPEED: st_speed_in  = csr_wdata[14:0];
            tstc_pkg::CSR_REVERSAL:      rev_speed_in = csr_wdata[14:0];
            tstc_pkg::CSR_SPEED_RATIO:   ratio_in     = csr_wdata[15:0];
            tstc_pkg::CSR_STEP_GAIN:     gain_in      = csr_wdata[15:0];
            tstc_pkg::CSR_THRESHOLD:     thresh_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_chg_in   = 1'b0;
               rsp_avg_in   = last_avg_ff;
               if (in_startup_ff && !start_over) begin
                  cur_speed_in = neg_startup;
                  tick_in      = tick_inc;
                  rsp_speed_in = neg_startup;
               end else begin
                  in_startup_in = 1'b0;
                  rsp_speed_in  = cur_speed_ff;
                  if (eval_now) begin
                     // The window closes: the result comes from the evaluation.
                     rsp_valid_in = 1'b0;
                     q_in         = sum_next;
                     sum_in       = '0;
                     tick_in      = '0;
                     state_in     = ST_ABS;
                  end else begin
                     sum_in  = sum_next;
                     tick_in = tick_inc;
                  end
               end
            end
         end
         ST_ABS: begin
            sum_neg_in = q_ff[47];
            q_in       = q_ff[47] ? ('0 - q_ff) : q_ff;
            rem_in     = '0;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            q_in    = {q_ff[46:0], sub_ge};
            rem_in  = sub_ge ? sub_diff[15:0] : div_rem_t[15:0];
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (sum_neg_ff) begin
               avg_in = q_over_neg ? 32'h8000_0000 : (32'd0 - q_ff[31:0]);
               q_in   = {16'b0, (q_over_neg ? 32'h8000_0000 : q_ff[31:0])};
            end else begin
               avg_in = q_over_pos ? 32'h7FFF_FFFF : q_ff[31:0];
               q_in   = {16'b0, (q_over_pos ? 32'h7FFF_FFFF : q_ff[31:0])};
            end
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // Two bits of the radicand enter per step, one root bit leaves.
            q_in    = {q_ff[45:0], 2'b00};
            rem_in  = sub_ge ? sub_diff[15:0] : sqrt_rem_t[15:0];
            root_in = {root_ff[14:0], sub_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = ST_MUL_TGT;
            end
         end
         ST_MUL_TGT: begin
            prod_in  = mul_res;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_neg_in = diff_up[20];
            dmag_in     = diff_up[20] ? diff_dn[19:0] : diff_up[19:0];
            state_in    = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            prod_in  = mul_res;
            state_in = ST_MUL_THR;
         end
         ST_MUL_THR: begin
            smag_in  = prod_ff[35:16];
            prod_in  = mul_res;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = next_speed;
               rsp_done_in  = 1'b1;
               rsp_avg_in   = avg_ff;
               rsp_chg_in   = (next_speed != cur_speed_ff);
               cur_speed_in = next_speed;
               last_avg_in  = avg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_win_ff   <= tstc_pkg::HALF_WINDOW_RESET;
         startup_ff    <= tstc_pkg::STARTUP_TICKS_RESET;
         st_speed_ff   <= tstc_pkg::STARTUP_SPEED_RESET;
         rev_speed_ff  <= tstc_pkg::REVERSAL_RESET;
         ratio_ff      <= tstc_pkg::SPEED_RATIO_RESET;
         gain_ff       <= tstc_pkg::STEP_GAIN_RESET;
         thresh_ff     <= tstc_pkg::THRESHOLD_RESET;
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         in_startup_ff <= 1'b1;
         sum_ff        <= '0;
         cur_speed_ff  <= 16'd0 - {1'b0, tstc_pkg::STARTUP_SPEED_RESET};
         last_avg_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         half_win_ff   <= half_win_in;
         startup_ff    <= startup_in;
         st_speed_ff   <= st_speed_in;
         rev_speed_ff  <= rev_speed_in;
         ratio_ff      <= ratio_in;
         gain_ff       <= gain_in;
         thresh_ff     <= thresh_in;
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         in_startup_ff <= in_startup_in;
         sum_ff        <= sum_in;
         cur_speed_ff  <= cur_speed_in;
         last_avg_ff   <= last_avg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      sum_neg_ff   <= sum_neg_in;
      avg_ff       <= avg_in;
      prod_ff      <= prod_in;
      dmag_ff      <= dmag_in;
      diff_neg_ff  <= diff_neg_in;
      smag_ff      <= smag_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_chg_ff   <= rsp_chg_in;
   end

   // Only an evaluation can report a changed speed.
   `TSTC_ASSERT_SAME(a_changed_needs_window,
      rsp_valid_ff && rsp_chg_ff, rsp_done_ff,
      "speed changed without window evaluation")
   // An evaluation never runs during startup.
   `TSTC_ASSERT_SAME(a_startup_idle,
      in_startup_ff, state_ff == ST_IDLE,
      "evaluation started during startup")
   // The window restarts as soon as an evaluation begins.
   `TSTC_ASSERT_SAME(a_window_cleared,
      state_ff != ST_IDLE, (tick_ff == '0) && (sum_ff == '0),
      "window not cleared during evaluation")
   // A finished evaluation shows up as a window result in the next cycle.
   `TSTC_ASSERT_NEXT(a_eval_result,
      (state_ff == ST_DECIDE) && out_free,
      rsp_valid_ff && rsp_done_ff && (state_ff == ST_IDLE),
      "evaluation result missing")

endmodule
